// ===== src/cbsr_pkg.sv =====
// Shared types, constants and helpers for the cartridge bank switch registers.
package cbsr_pkg;

	localparam int PatternSlots   = 8;
	localparam int SlotIdxWidth   = $clog2(PatternSlots);
	localparam int AddrWidth      = 16;
	localparam int DataWidth      = 8;
	localparam int ProgBankWidth  = 4;
	localparam int MirrorWidth    = 2;
	localparam int PatBankWidth   = 8;
	localparam int CfgIndexWidth  = 2;
	localparam int CfgDataWidth   = 8;

	localparam int InBits         = AddrWidth + DataWidth;
	localparam int InTdataWidth   = ((InBits + 7) / 8) * 8;
	localparam int ResultBits     = 2 * ProgBankWidth + MirrorWidth + PatternSlots * PatBankWidth;
	localparam int OutTdataWidth  = ((ResultBits + 7) / 8) * 8;
	localparam int OutPadWidth    = OutTdataWidth - ResultBits;

	// top address nibble decodes
	localparam logic [3:0] PageProgram0     = 4'h8;
	localparam logic [3:0] PageMirror       = 4'h9;
	localparam logic [3:0] PageProgram1     = 4'hA;
	localparam logic [3:0] PagePatternFirst = 4'hB;
	localparam logic [3:0] PagePattern1     = 4'hC;
	localparam logic [3:0] PagePattern2     = 4'hD;
	localparam logic [3:0] PagePatternLast  = 4'hE;

	typedef enum logic [CfgIndexWidth-1:0] {
		CfgRevision   = 2'd0,
		CfgProgramMax = 2'd1,
		CfgPatternMax = 2'd2
	} cfg_index_t;

	localparam logic [CfgDataWidth-1:0] ProgramMaxReset = 8'd15;
	localparam logic [CfgDataWidth-1:0] PatternMaxReset = 8'd255;

	typedef struct packed {
		logic                                      revision;
		logic [CfgDataWidth-1:0]                   program_max;
		logic [CfgDataWidth-1:0]                   pattern_max;
	} cfg_t;

	typedef struct packed {
		logic [PatternSlots-1:0][PatBankWidth-1:0] pattern_bank;
		logic [MirrorWidth-1:0]                    mirror;
		logic [1:0][ProgBankWidth-1:0]             program_bank;
	} bank_state_t;

	function automatic bank_state_t bank_state_reset();
		bank_state_t s;
		s.program_bank[0] = ProgBankWidth'(0);
		s.program_bank[1] = ProgBankWidth'(1);
		s.mirror          = '0;
		for (int i = 0; i < PatternSlots; i++) begin
			s.pattern_bank[i] = PatBankWidth'(i);
		end
		return s;
	endfunction

	// over-limit values are folded back by masking with the limit
	function automatic logic [7:0] clamp_bank(input logic [7:0] v, input logic [7:0] limit);
		return (v > limit) ? (v & limit) : v;
	endfunction

endpackage

// ===== src/cbsr_bank_update.sv =====
// Address decode and next-state logic for one CPU write.
module cbsr_bank_update
	import cbsr_pkg::*;
(
	input  bank_state_t            cur,
	input  cfg_t                   cfg,
	input  logic [AddrWidth-1:0]   address,
	input  logic [DataWidth-1:0]   data,
	output bank_state_t            nxt
);

	logic [3:0]              page;
	logic [1:0]              low;
	logic [3:0]              page_off;
	logic [SlotIdxWidth-1:0] slot;
	logic [3:0]              nib;
	logic [7:0]              prog_v;
	logic [7:0]              pat_v;
	logic [7:0]              pat_cur;

	assign page     = address[15:12];
	// revision 1 swaps A0 and A1
	assign low      = cfg.revision ? {address[0], address[1]} : address[1:0];
	assign page_off = page - PagePatternFirst;
	assign slot     = {page_off[1:0], low[1]};
	assign nib      = cfg.revision ? data[4:1] : data[3:0];
	assign prog_v   = clamp_bank({4'h0, data[3:0]}, cfg.program_max);
	assign pat_cur  = cur.pattern_bank[slot];
	assign pat_v    = clamp_bank(low[0] ? {nib, pat_cur[3:0]} : {pat_cur[7:4], nib},
		cfg.pattern_max);

	always_comb begin
		nxt = cur;
		case (page)
			PageProgram0: begin
				nxt.program_bank[0] = prog_v[3:0];
			end
			PageProgram1: begin
				nxt.program_bank[1] = prog_v[3:0];
			end
			PageMirror: begin
				nxt.mirror = data[1:0];
			end
			PagePatternFirst, PagePattern1, PagePattern2, PagePatternLast: begin
				nxt.pattern_bank[slot] = pat_v;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== src/cartridge_bank_switch_registers_unit.sv =====
// Top level: bank switch register file with stream input/output and config port.
// Each accepted CPU write (address, data) yields one result carrying every bank
// register after that write. One write is accepted per clock unless the output stalls.
// A write lands in the input register at its accepting edge. Decode and state update
// fill the result register once it is free, and the result is offered from there.
// The result register is freed as it is taken, so a new write enters while a
// finished result is still waiting. Configuration is always ready; cfg_index values
// beyond the third register are ignored.
module cartridge_bank_switch_registers_unit
	import cbsr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// config write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,
	// CPU write stream
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [InTdataWidth-1:0]  s_axis_tdata,   // address[15:0], data[23:16]
	// bank register stream
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [OutTdataWidth-1:0] m_axis_tdata    // program_bank_first[3:0],
	                                                 // program_bank_second[7:4],
	                                                 // mirroring_mode[9:8],
	                                                 // pattern_bank_0..7[73:10], zero pad
);

	cfg_t                 cfg_q;
	logic                 valid_s1;
	logic [AddrWidth-1:0] address_s1;
	logic [DataWidth-1:0] data_s1;
	bank_state_t          state_q;
	bank_state_t          state_nxt;
	bank_state_t          result_q;
	logic                 result_valid_q;
	logic                 result_free;
	logic                 advance;
	logic                 in_xact;

	assign cfg_ready     = 1'b1;
	assign result_free   = !result_valid_q || m_axis_tready;
	assign advance       = valid_s1 && result_free;
	assign s_axis_tready = !valid_s1 || result_free;
	assign in_xact       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.revision    <= 1'b0;
			cfg_q.program_max <= ProgramMaxReset;
			cfg_q.pattern_max <= PatternMaxReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				CfgRevision:   cfg_q.revision    <= cfg_data[0];
				CfgProgramMax: cfg_q.program_max <= cfg_data;
				CfgPatternMax: cfg_q.pattern_max <= cfg_data;
				default:       cfg_q             <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xact) begin
			address_s1 <= s_axis_tdata[AddrWidth-1:0];
			data_s1    <= s_axis_tdata[AddrWidth +: DataWidth];
		end
	end

	cbsr_bank_update u_update (
		.cur     (state_q),
		.cfg     (cfg_q),
		.address (address_s1),
		.data    (data_s1),
		.nxt     (state_nxt)
	);

	// bank state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= bank_state_reset();
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (result_free) begin
				result_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= state_nxt;
		end
	end

	assign m_axis_tvalid = result_valid_q;
	assign m_axis_tdata  = {{OutPadWidth{1'b0}}, result_q.pattern_bank, result_q.mirror,
		result_q.program_bank[1], result_q.program_bank[0]};

endmodule

// ===== verif/cartridge_bank_switch_registers_unit_tb.sv =====
// Self-checking testbench for the cartridge bank switch register unit.
module cartridge_bank_switch_registers_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cbsr_pkg::*;

	typedef struct packed {
		logic [PatternSlots-1:0][PatBankWidth-1:0] pattern;
		logic [MirrorWidth-1:0]                    mirror;
		logic [ProgBankWidth-1:0]                  second;
		logic [ProgBankWidth-1:0]                  first;
	} bank_view_t;

	typedef enum {RowWrite, RowConfig} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		logic [AddrWidth-1:0]     addr;
		logic [DataWidth-1:0]     data;
		logic [CfgIndexWidth-1:0] index;
		bit                       golden_given;
		bank_view_t               golden;
	} stim_row_t;

	// index past the last register, must be ignored by the block
	localparam logic [CfgIndexWidth-1:0] CfgUnused = 2'd3;
	localparam logic [PatternSlots-1:0][PatBankWidth-1:0] PatternReset = 64'h0706050403020100;
	localparam int unsigned SectionItems = 305;
	localparam int unsigned HoldCycles = 300;
	localparam int unsigned SendIdlePct[3] = '{34, 61, 0};
	localparam int unsigned RecvIdlePct[3] = '{61, 34, 0};
	localparam logic [7:0] ProgMaxPlan[6] = '{8'd255, 8'd0, 8'd5, 8'd15, 8'd255, 8'd2};
	localparam logic [7:0] PatMaxPlan[6] = '{8'd0, 8'd255, 8'd15, 8'd200, 8'd255, 8'd63};
	localparam bit RevisionPlan[6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CfgIndexWidth-1:0] cfg_index;
	logic [CfgDataWidth-1:0]  cfg_data;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	logic [InTdataWidth-1:0]  s_axis_tdata;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	logic [OutTdataWidth-1:0] m_axis_tdata;

	// predictor copy of the registers and bank state
	logic                                      rev_m;
	logic [7:0]                                prog_max_m;
	logic [7:0]                                pat_max_m;
	logic [1:0][ProgBankWidth-1:0]             prog_m;
	logic [MirrorWidth-1:0]                    mirror_m;
	logic [PatternSlots-1:0][PatBankWidth-1:0] pat_m;

	bank_view_t  pending_banks[$];
	stim_row_t   directed_rows[$];
	int unsigned idle_mode;
	bit          hold_request;
	int unsigned hold_count;
	int unsigned mismatches;
	int unsigned results_checked;
	int unsigned writes_sent;
	int unsigned regs_written;

	cartridge_bank_switch_registers_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic bank_view_t banks_of(logic [3:0] f, logic [3:0] s, logic [1:0] m,
			logic [PatternSlots-1:0][PatBankWidth-1:0] p);
		bank_view_t v;
		v.first   = f;
		v.second  = s;
		v.mirror  = m;
		v.pattern = p;
		return v;
	endfunction

	function automatic void reset_model();
		rev_m      = 1'b0;
		prog_max_m = ProgramMaxReset;
		pat_max_m  = PatternMaxReset;
		prog_m[0]  = 4'd0;
		prog_m[1]  = 4'd1;
		mirror_m   = '0;
		pat_m      = PatternReset;
	endfunction

	function automatic void apply_register_write(logic [CfgIndexWidth-1:0] idx, logic [7:0] val);
		case (idx)
			CfgRevision:   rev_m = val[0];
			CfgProgramMax: prog_max_m = val;
			CfgPatternMax: pat_max_m = val;
			default: ;
		endcase
	endfunction

	// bank state after one CPU write
	function automatic bank_view_t apply_cpu_write(logic [AddrWidth-1:0] addr,
			logic [DataWidth-1:0] data);
		logic [3:0] page;
		logic [1:0] lines;
		logic [2:0] slot;
		logic [3:0] nib;
		logic [7:0] merged;
		page = addr[15:12];
		if (page < PagePatternFirst) begin
			if (page == PageProgram0 || page == PageProgram1) begin
				merged = {4'h0, data[3:0]};
				if (merged > prog_max_m) merged &= prog_max_m;
				prog_m[page == PageProgram1] = merged[3:0];
			end else if (page == PageMirror) begin
				mirror_m = data[1:0];
			end
		end else if (page <= PagePatternLast) begin
			// revision 1 boards cross A0/A1 and feed the data one bit down
			lines  = rev_m ? {addr[0], addr[1]} : addr[1:0];
			slot   = {2'(page - PagePatternFirst), lines[1]};
			nib    = rev_m ? data[4:1] : data[3:0];
			merged = lines[0] ? {nib, pat_m[slot][3:0]} : {pat_m[slot][7:4], nib};
			if (merged > pat_max_m) merged &= pat_max_m;
			pat_m[slot] = merged;
		end
		return banks_of(prog_m[0], prog_m[1], mirror_m, pat_m);
	endfunction

	function automatic void add_write(logic [15:0] a, logic [7:0] d);
		stim_row_t r;
		r.kind = RowWrite;
		r.addr = a;
		r.data = d;
		r.index = '0;
		r.golden_given = 1'b0;
		r.golden = '0;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_golden(logic [15:0] a, logic [7:0] d, bank_view_t g);
		stim_row_t r;
		r.kind = RowWrite;
		r.addr = a;
		r.data = d;
		r.index = '0;
		r.golden_given = 1'b1;
		r.golden = g;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_config(logic [CfgIndexWidth-1:0] idx, logic [7:0] val);
		stim_row_t r;
		r.kind = RowConfig;
		r.addr = '0;
		r.data = val;
		r.index = idx;
		r.golden_given = 1'b0;
		r.golden = '0;
		directed_rows.push_back(r);
	endfunction

	task automatic note_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] mismatch %s: expected %0h, got %0h", $realtime, name, want, got);
		end
	endtask

	// one CPU write; returns at the edge where it is taken
	task automatic send_write(logic [AddrWidth-1:0] addr, logic [DataWidth-1:0] data);
		@(negedge clk);
		while ($urandom_range(0, 99) < SendIdlePct[idle_mode]) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {data, addr};
		do @(posedge clk); while (!s_axis_tready);
		writes_sent++;
	endtask

	task automatic write_register(logic [CfgIndexWidth-1:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_register_write(idx, val);
		regs_written++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering and let every pending snapshot come back before going on
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_banks.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// output side pacing, with the optional long hold-off
	initial begin
		m_axis_tready = 1'b0;
		hold_count = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				for (hold_count = 0; hold_count < HoldCycles; hold_count++) @(negedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= RecvIdlePct[idle_mode]);
			end
		end
	end

	always @(posedge clk) begin
		bank_view_t want;
		bank_view_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[ResultBits-1:0];
			if (pending_banks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result with nothing pending: %0h", $realtime, m_axis_tdata);
			end else begin
				want = pending_banks.pop_front();
				results_checked++;
				note_field("program_bank_first", want.first, got.first);
				note_field("program_bank_second", want.second, got.second);
				note_field("mirroring_mode", want.mirror, got.mirror);
				for (int i = 0; i < PatternSlots; i++)
					note_field($sformatf("pattern_bank_%0d", i), want.pattern[i], got.pattern[i]);
				note_field("pad", '0, m_axis_tdata[OutTdataWidth-1:ResultBits]);
			end
		end
	end

	initial begin
		int unsigned pick;
		logic [AddrWidth-1:0] addr;
		logic [DataWidth-1:0] data;
		logic [7:0] prog_max;
		logic [7:0] pat_max;
		bank_view_t pred;

		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		idle_mode     = 0;
		hold_request  = 1'b0;
		mismatches    = 0;
		results_checked = 0;
		writes_sent   = 0;
		regs_written  = 0;
		reset_model();

		// reset state, program/mirror extremes and unmapped pages
		add_golden(16'h0000, 8'hFF, banks_of(4'd0, 4'd1, 2'd0, PatternReset));
		add_golden(16'h8000, 8'hFF, banks_of(4'd15, 4'd1, 2'd0, PatternReset));
		add_golden(16'hAFFF, 8'h0F, banks_of(4'd15, 4'd15, 2'd0, PatternReset));
		add_golden(16'h9FFF, 8'hFF, banks_of(4'd15, 4'd15, 2'd3, PatternReset));
		add_golden(16'hFFFF, 8'hAA, banks_of(4'd15, 4'd15, 2'd3, PatternReset));
		add_golden(16'h7FFF, 8'h55, banks_of(4'd15, 4'd15, 2'd3, PatternReset));
		// nibble writes to pattern slots
		add_write(16'hB000, 8'h5A);
		add_write(16'hB001, 8'hF3);
		add_write(16'hC002, 8'h1F);
		add_write(16'hC003, 8'hE0);
		add_write(16'hD001, 8'hFF);
		add_write(16'hE003, 8'hFF);
		add_write(16'hEFFE, 8'h00);
		// swapped address lines and shifted data
		add_config(CfgRevision, 8'd1);
		add_write(16'hB001, 8'hFF);
		add_write(16'hE002, 8'h1E);
		// program clamp
		add_config(CfgProgramMax, 8'd0);
		add_write(16'h8000, 8'h0F);
		add_config(CfgProgramMax, 8'd5);
		add_write(16'hA000, 8'h07);
		// pattern clamp, then an ignored register index
		add_config(CfgPatternMax, 8'h3F);
		add_write(16'hC000, 8'hFF);
		add_config(CfgUnused, 8'hFF);
		add_write(16'hC001, 8'hF0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == RowConfig) begin
				drain();
				write_register(directed_rows[i].index, directed_rows[i].data);
			end else begin
				send_write(directed_rows[i].addr, directed_rows[i].data);
				pred = apply_cpu_write(directed_rows[i].addr, directed_rows[i].data);
				pending_banks.push_back(directed_rows[i].golden_given ?
					directed_rows[i].golden : pred);
			end
		end

		for (int section = 0; section < 6; section++) begin
			drain();
			idle_mode = section / 2;
			prog_max = (section == 5) ? 8'($urandom) : ProgMaxPlan[section];
			pat_max  = (section == 5) ? 8'($urandom) : PatMaxPlan[section];
			// upper bits of the revision write must be dropped
			write_register(CfgRevision, {7'($urandom), RevisionPlan[section]});
			write_register(CfgProgramMax, prog_max);
			write_register(CfgPatternMax, pat_max);
			write_register(CfgUnused, 8'($urandom));
			if (section == 4) hold_request = 1'b1;
			repeat (SectionItems) begin
				pick = $urandom_range(0, 99);
				if (pick < 75)
					addr = {4'($urandom_range(8, 14)), 12'($urandom)};
				else if (pick < 85)
					addr = 16'($urandom);
				else if (pick < 93)
					addr = {4'($urandom_range(0, 7)), 12'($urandom)};
				else
					addr = {4'hF, 12'($urandom)};
				pick = $urandom_range(0, 9);
				data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
				send_write(addr, data);
				pending_banks.push_back(apply_cpu_write(addr, data));
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Ran %0d CPU writes and %0d register writes in three pacing modes, one long output hold.",
			writes_sent, regs_written);
		$display("Checked %0d bank snapshots, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
